@@ rtl/core/rau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// action codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_RED = 3'd4;
	localparam logic [2:0] ACT_EQ  = 3'd5;
endpackage

@@ rtl/core/rau_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// valid/ready channels carrying operand and result words
// ----------------------------------------------------------------------------
interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
	logic                            valid;
	logic                            ready;
	logic [2:0]                      action;
	logic signed [OPERAND_WIDTH-1:0] a_num;
	logic [OPERAND_WIDTH-2:0]        a_den;
	logic signed [OPERAND_WIDTH-1:0] b_num;
	logic [OPERAND_WIDTH-2:0]        b_den;
	modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_num;
	logic signed [31:0] out_den;
	logic               is_equal;
	modport source (output valid, out_num, out_den, is_equal, input ready);
	modport sink (input valid, out_num, out_den, is_equal, output ready);
endinterface

@@ rtl/core/rau_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module rau_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  q_q, r_q, d_q;
	logic [W:0]    trial;

	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;
endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, subtract, multiply, divide, reduce and compare
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | action, a_num, a_den, b_num, b_den
//  out_ch  | out | out_num, out_den, is_equal
//  mul, sub, div and unused codes: result registered in ST_MUL1, offered
//  in ST_OUT after ST_MUL2. add, reduce and compare run euclid by repeated
//  division on the shared 32-bit divider, then divide by the gcd twice
//  unless it is zero; compare does this once for each operand.
//  one word at a time: in_ch.ready is low from acceptance until the result
//  word is taken. reset clears the sequencer only; an output stall just
//  holds the result register.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	rau_in_if.sink    in_ch,
	rau_out_if.source out_ch
);
	localparam int W = 32;
	localparam logic [3:0] ST_IDLE = 4'd0, ST_MUL1 = 4'd1, ST_MUL2 = 4'd2,
		ST_GCD = 4'd3, ST_GWAIT = 4'd4, ST_DIV1 = 4'd5, ST_DWAIT1 = 4'd6,
		ST_DIV2 = 4'd7, ST_DWAIT2 = 4'd8, ST_FIN = 4'd9, ST_OUT = 4'd10;

	logic [3:0] state_q;
	logic [2:0] act_q;
	logic       pass_q;
	logic signed [W-1:0] an_q, bn_q, ad_q, bd_q;
	logic [W-1:0] gx_q, gy_q, g_q, t1_q, n1_q, d1_q;
	logic         neg_q, eq_q;
	logic signed [W-1:0] rn_q, rd_q;
	logic [W-1:0] mag_n;
	logic [W-1:0] rn_v, rd_v;
	logic         dv_start;
	logic [W-1:0] dv_n, dv_d, dv_q, dv_r;
	logic         dv_done;
	logic signed [2*W-1:0] p1, p2;

	rau_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_n),
		.divisor(dv_d), .done(dv_done), .quot(dv_q), .rem(dv_r)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.out_num  = rn_q;
	assign out_ch.out_den  = rd_q;
	assign out_ch.is_equal = eq_q;

	// current fraction for reduce: pass_q selects b in the second compare pass
	assign mag_n = pass_q ? (bn_q[W-1] ? W'(-bn_q) : bn_q) :
	                        (an_q[W-1] ? W'(-an_q) : an_q);

	assign p1 = an_q * bd_q;
	assign p2 = ad_q * bn_q;

	always_comb begin
		if (gx_q == '0) begin
			rn_v = pass_q ? bn_q : an_q;
			rd_v = pass_q ? bd_q : ad_q;
		end else begin
			rn_v = neg_q ? W'(-n1_q) : n1_q;
			rd_v = d1_q;
		end
	end

	always_comb begin
		dv_start = 1'b0;
		dv_n = gx_q;
		dv_d = gy_q;
		case (state_q)
			ST_GCD: dv_start = (gy_q != '0);
			ST_DIV1: begin
				dv_start = 1'b1;
				dv_n = (act_q == rau_pkg::ACT_ADD) ? ad_q : t1_q;
				dv_d = g_q;
			end
			ST_DIV2: begin
				dv_start = 1'b1;
				dv_n = (act_q == rau_pkg::ACT_ADD) ? bd_q : (pass_q ? bd_q : ad_q);
				dv_d = g_q;
			end
			default: dv_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					state_q <= (in_ch.action == rau_pkg::ACT_ADD ||
						in_ch.action == rau_pkg::ACT_RED ||
						in_ch.action == rau_pkg::ACT_EQ) ? ST_GCD : ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_GCD: state_q <= (gy_q != '0) ? ST_GWAIT :
					(gx_q == '0 ? ST_FIN : ST_DIV1);
				ST_GWAIT: if (dv_done) state_q <= ST_GCD;
				ST_DIV1: state_q <= ST_DWAIT1;
				ST_DWAIT1: if (dv_done) state_q <= ST_DIV2;
				ST_DIV2: state_q <= ST_DWAIT2;
				ST_DWAIT2: if (dv_done) state_q <= ST_FIN;
				ST_FIN: state_q <= (act_q == rau_pkg::ACT_EQ && !pass_q) ? ST_GCD : ST_OUT;
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q  <= in_ch.action;
				an_q   <= W'(in_ch.a_num);
				bn_q   <= W'(in_ch.b_num);
				ad_q   <= W'({1'b0, in_ch.a_den});
				bd_q   <= W'({1'b0, in_ch.b_den});
				pass_q <= 1'b0;
				eq_q   <= 1'b0;
				rn_q   <= '0;
				rd_q   <= '0;
				if (in_ch.action == rau_pkg::ACT_ADD) begin
					gx_q <= W'({1'b0, in_ch.a_den});
					gy_q <= W'({1'b0, in_ch.b_den});
				end else begin
					gx_q <= in_ch.a_num[OPERAND_WIDTH-1] ?
						W'(-W'(in_ch.a_num)) : W'(in_ch.a_num);
					gy_q <= W'({1'b0, in_ch.a_den});
				end
			end
			ST_MUL1: begin
				case (act_q)
					rau_pkg::ACT_SUB: begin
						if (ad_q == bd_q) begin
							rn_q <= an_q - bn_q;
							rd_q <= ad_q;
						end else begin
							rn_q <= W'(p1 - p2);
							rd_q <= W'(ad_q * bd_q);
						end
					end
					rau_pkg::ACT_MUL: begin
						rn_q <= W'(an_q * bn_q);
						rd_q <= W'(ad_q * bd_q);
					end
					rau_pkg::ACT_DIV: begin
						rn_q <= W'(p1);
						rd_q <= W'(p2);
					end
					default: begin
						rn_q <= '0;
						rd_q <= '0;
					end
				endcase
			end
			ST_GCD: begin
				g_q  <= gx_q;
				t1_q <= mag_n;
				neg_q <= pass_q ? bn_q[W-1] : an_q[W-1];
			end
			ST_GWAIT: if (dv_done) begin
				gx_q <= gy_q;
				gy_q <= dv_r;
			end
			ST_DWAIT1: if (dv_done) n1_q <= dv_q;
			ST_DWAIT2: if (dv_done) begin
				if (act_q == rau_pkg::ACT_ADD) begin
					rd_q <= W'(n1_q * bd_q);
					t1_q <= n1_q;
					n1_q <= dv_q;
				end else begin
					d1_q <= dv_q;
				end
			end
			ST_FIN: begin
				if (act_q == rau_pkg::ACT_ADD) begin
					// l = ad/g*bd; fa = bd/g, fb = ad/g
					if (ad_q == '0 || bd_q == '0) begin
						rn_q <= '0;
						rd_q <= '0;
					end else begin
						rn_q <= W'(n1_q * an_q + t1_q * bn_q);
					end
				end else if (act_q == rau_pkg::ACT_RED) begin
					rn_q <= rn_v;
					rd_q <= rd_v;
				end else if (!pass_q) begin
					rn_q <= rn_v;
					rd_q <= rd_v;
					pass_q <= 1'b1;
					gx_q <= bn_q[W-1] ? W'(-bn_q) : bn_q;
					gy_q <= bd_q;
				end else begin
					eq_q <= (rn_q == rn_v) && (rd_q == rd_v);
					rn_q <= '0;
					rd_q <= '0;
				end
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/core/rau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks for the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_num,
	input logic is_equal
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_num))
		else $error("result dropped");
	a_eq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_equal |-> out_num == 32'd0) else $error("compare num");
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("no return to idle");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_num(out_ch.out_num), .is_equal(out_ch.is_equal)
);

@@ tb/rational_arithmetic_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// drives fraction words through the unit with random gaps on both channels and
// checks the result words against a behavioural fraction calculator, after a
// short table of directed words, some with hand-derived results
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
	localparam int W = 16;
	localparam int N_RAND = 1200;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] a_num;
		logic [14:0]        a_den;
		logic signed [15:0] b_num;
		logic [14:0]        b_den;
	} word_in_t;

	typedef struct packed {
		logic signed [31:0] num;
		logic signed [31:0] den;
		logic               eq;
	} word_out_t;

	typedef struct {
		word_in_t  w;
		logic      known;
		word_out_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rau_in_if #(.OPERAND_WIDTH(W)) in_ch ();
	rau_out_if out_ch ();

	rational_arithmetic_unit #(.OPERAND_WIDTH(W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	word_out_t pending[$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	int n_act[8];
	bit sending_done = 1'b0;

	function automatic longint gcd_of(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic void reduce_frac(longint n, longint d, output longint rn,
		output longint rd);
		longint g, m;
		m = (n < 0) ? -n : n;
		g = gcd_of(m, d);
		if (g == 0) begin
			rn = n;
			rd = d;
		end else begin
			rn = (n < 0) ? -(m / g) : m / g;
			rd = d / g;
		end
	endfunction

	function automatic word_out_t fraction_result(word_in_t w);
		longint an, ad, bn, bd, l, fa, fb, rn, rd, n1, d1, n2, d2;
		word_out_t r;
		an = w.a_num;
		ad = w.a_den;
		bn = w.b_num;
		bd = w.b_den;
		rn = 0;
		rd = 0;
		r.eq = 1'b0;
		case (w.action)
			rau_pkg::ACT_ADD: begin
				l = (ad != 0 && bd != 0) ? (ad / gcd_of(ad, bd)) * bd : 0;
				fa = (ad != 0) ? l / ad : 0;
				fb = (bd != 0) ? l / bd : 0;
				rn = fa * an + fb * bn;
				rd = l;
			end
			rau_pkg::ACT_SUB: begin
				if (ad == bd) begin
					rn = an - bn;
					rd = ad;
				end else begin
					rn = an * bd - ad * bn;
					rd = ad * bd;
				end
			end
			rau_pkg::ACT_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			rau_pkg::ACT_DIV: begin
				rn = an * bd;
				rd = ad * bn;
			end
			rau_pkg::ACT_RED: reduce_frac(an, ad, rn, rd);
			rau_pkg::ACT_EQ: begin
				reduce_frac(an, ad, n1, d1);
				reduce_frac(bn, bd, n2, d2);
				r.eq = (n1 == n2 && d1 == d2);
			end
			default: ;
		endcase
		r.num = rn[31:0];
		r.den = rd[31:0];
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch: word %0d %s got %0d expected %0d", n_got, what, got, want);
	endtask

	task automatic send_word(word_in_t w, logic known, word_out_t r);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.action <= w.action;
		in_ch.a_num  <= w.a_num;
		in_ch.a_den  <= w.a_den;
		in_ch.b_num  <= w.b_num;
		in_ch.b_den  <= w.b_den;
		in_ch.valid  <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending.push_back(known ? r : fraction_result(w));
		n_act[w.action]++;
		n_sent++;
		@(negedge clk);
	endtask

	function automatic word_in_t random_word();
		word_in_t w;
		int k;
		w.action = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) :
			3'($urandom_range(0, 5));
		k = $urandom_range(0, 3);
		w.a_num = (k == 0) ? 16'($signed($urandom_range(0, 40)) - 20) : 16'($urandom);
		w.b_num = (k == 1) ? 16'($signed($urandom_range(0, 40)) - 20) : 16'($urandom);
		w.a_den = (k == 2) ? 15'($urandom_range(1, 60)) : 15'($urandom_range(1, 32767));
		w.b_den = (k != 3) ? 15'($urandom_range(1, 60)) : 15'($urandom_range(1, 32767));
		if (w.action == rau_pkg::ACT_EQ && $urandom_range(0, 1)) begin
			k = $urandom_range(1, 6);
			w.b_num = 16'(w.a_num / k);
			w.b_den = 15'(w.a_den / k == 0 ? 1 : w.a_den / k);
			if ($urandom_range(0, 1)) begin
				w.a_num = 16'(w.b_num * k);
				w.a_den = 15'(w.b_den * k);
			end
		end
		return w;
	endfunction

	// ready side: random stall per word, then compare with oldest expectation
	initial begin
		word_out_t e;
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 18);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			if (pending.size() == 0) begin
				report("unexpected word", out_ch.out_num, 0);
			end else begin
				e = pending.pop_front();
				if (out_ch.out_num !== e.num) report("out_num", out_ch.out_num, e.num);
				if (out_ch.out_den !== e.den) report("out_den", out_ch.out_den, e.den);
				if (out_ch.is_equal !== e.eq) report("is_equal", out_ch.is_equal, e.eq);
			end
			n_got++;
			@(negedge clk);
		end
	end

	initial begin
		row_t rows[$];
		word_in_t w;
		int wait_n;
		in_ch.valid = 1'b0;
		in_ch.action = rau_pkg::ACT_ADD;
		in_ch.a_num = '0;
		in_ch.a_den = 15'd1;
		in_ch.b_num = '0;
		in_ch.b_den = 15'd1;
		rows = '{
			'{'{rau_pkg::ACT_ADD, 16'sd1, 15'd2, 16'sd1, 15'd3}, 1'b1,
				'{32'sd5, 32'sd6, 1'b0}},
			'{'{rau_pkg::ACT_ADD, 16'sd1, 15'd4, 16'sd1, 15'd6}, 1'b1,
				'{32'sd5, 32'sd12, 1'b0}},
			'{'{rau_pkg::ACT_ADD, 16'sd3, 15'd0, 16'sd1, 15'd5}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0}},
			'{'{rau_pkg::ACT_ADD, -16'sd32768, 15'd32767, 16'sd32767, 15'd32766}, 1'b0,
				'{0, 0, 0}},
			'{'{rau_pkg::ACT_SUB, 16'sd3, 15'd7, 16'sd5, 15'd7}, 1'b1,
				'{-32'sd2, 32'sd7, 1'b0}},
			'{'{rau_pkg::ACT_SUB, -16'sd32768, 15'd32767, 16'sd32767, 15'd1}, 1'b0,
				'{0, 0, 0}},
			'{'{rau_pkg::ACT_SUB, 16'sd1, 15'd0, 16'sd1, 15'd3}, 1'b0, '{0, 0, 0}},
			'{'{rau_pkg::ACT_MUL, -16'sd32768, 15'd32767, -16'sd32768, 15'd32767}, 1'b1,
				'{32'sd1073741824, 32'sd1073676289, 1'b0}},
			'{'{rau_pkg::ACT_MUL, 16'sd32767, 15'd1, -16'sd32768, 15'd2}, 1'b0,
				'{0, 0, 0}},
			'{'{rau_pkg::ACT_DIV, 16'sd5, 15'd3, 16'sd0, 15'd9}, 1'b1,
				'{32'sd45, 32'sd0, 1'b0}},
			'{'{rau_pkg::ACT_DIV, 16'sd5, 15'd3, -16'sd2, 15'd9}, 1'b1,
				'{32'sd45, -32'sd6, 1'b0}},
			'{'{rau_pkg::ACT_DIV, -16'sd32768, 15'd32767, 16'sd32767, 15'd32767}, 1'b0,
				'{0, 0, 0}},
			'{'{rau_pkg::ACT_RED, 16'sd0, 15'd9, 16'sd7, 15'd1}, 1'b1,
				'{32'sd0, 32'sd1, 1'b0}},
			'{'{rau_pkg::ACT_RED, 16'sd0, 15'd0, 16'sd7, 15'd1}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0}},
			'{'{rau_pkg::ACT_RED, -16'sd12, 15'd18, -16'sd1, 15'd32767}, 1'b1,
				'{-32'sd2, 32'sd3, 1'b0}},
			'{'{rau_pkg::ACT_RED, -16'sd32768, 15'd32767, 16'sd0, 15'd1}, 1'b0,
				'{0, 0, 0}},
			'{'{rau_pkg::ACT_RED, 16'sd12, 15'd0, 16'sd0, 15'd1}, 1'b1,
				'{32'sd1, 32'sd0, 1'b0}},
			'{'{rau_pkg::ACT_EQ, 16'sd2, 15'd4, 16'sd1, 15'd2}, 1'b1,
				'{32'sd0, 32'sd0, 1'b1}},
			'{'{rau_pkg::ACT_EQ, -16'sd2, 15'd4, 16'sd1, 15'd2}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0}},
			'{'{rau_pkg::ACT_EQ, 16'sd0, 15'd5, 16'sd0, 15'd32767}, 1'b1,
				'{32'sd0, 32'sd0, 1'b1}},
			'{'{3'd6, 16'sd7, 15'd3, 16'sd2, 15'd5}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
			'{'{3'd7, -16'sd1, 15'd32767, -16'sd1, 15'd32767}, 1'b1,
				'{32'sd0, 32'sd0, 1'b0}}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i]) send_word(rows[i].w, rows[i].known, rows[i].r);
		repeat (N_RAND) begin
			w = random_word();
			send_word(w, 1'b0, '0);
		end
		in_ch.valid <= 1'b0;
		wait_n = 0;
		while (pending.size() != 0 && wait_n < 200000) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (500) @(posedge clk);
		$display("sent %0d words, checked %0d results", n_sent, n_got);
		$display("per action: add %0d sub %0d mul %0d div %0d red %0d eq %0d unused %0d",
			n_act[0], n_act[1], n_act[2], n_act[3], n_act[4], n_act[5],
			n_act[6] + n_act[7]);
		if (errors == 0 && pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit.sv
rtl/core/rau_checker.sv
tb/rational_arithmetic_unit_test.sv
